[src/rfdc_pkg.sv]
package rfdc_pkg;

  // Frame delimiters
  localparam logic [7:0] SyncA = 8'h53;
  localparam logic [7:0] SyncB = 8'h59;
  localparam logic [7:0] EndA  = 8'h54;
  localparam logic [7:0] EndB  = 8'h43;

  // Classification codes
  localparam logic [7:0] FallCtrl  = 8'h83;
  localparam logic [7:0] FallCmd   = 8'h01;
  localparam logic [7:0] FallData  = 8'h01;
  localparam logic [7:0] MoveCtrl  = 8'h80;
  localparam logic [7:0] MoveCmd   = 8'h03;
  localparam logic [7:0] MoveLenHi = 8'h00;
  localparam logic [7:0] MoveLenLo = 8'h01;

  // Frame byte positions and lengths
  localparam logic [7:0] PosCtrl   = 8'd2;
  localparam logic [7:0] PosCmd    = 8'd3;
  localparam logic [7:0] PosLenHi  = 8'd4;
  localparam logic [7:0] PosLenLo  = 8'd5;
  localparam logic [7:0] PosData   = 8'd6;
  localparam logic [7:0] HeaderLen = 8'd2;
  localparam logic [7:0] ReportLen = 8'd10;

  typedef struct packed {
    logic       fall_event;
    logic       movement_report;
    logic [7:0] movement_value;
    logic [7:0] frame_length;
    logic       overflow;
  } rfdc_result_t;

endpackage

[src/rfdc_byte_if.sv]
interface rfdc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

[src/rfdc_result_if.sv]
interface rfdc_result_if;
  logic       valid;
  logic       ready;
  logic       fall_event;
  logic       movement_report;
  logic [7:0] movement_value;
  logic [7:0] frame_length;
  logic       overflow;

  modport source (
    output valid, output fall_event, output movement_report,
    output movement_value, output frame_length, output overflow,
    input ready
  );
  modport sink (
    input valid, input fall_event, input movement_report,
    input movement_value, input frame_length, input overflow,
    output ready
  );
endinterface

[src/rfdc_parser.sv]
module rfdc_parser
  import rfdc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_LEN = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   byte_i,
  output logic         emit_o,
  output rfdc_result_t result_o
);

  localparam logic [7:0] MaxLen = 8'(MAX_FRAME_LEN);

  logic       in_frame_q, in_frame_d;
  logic [7:0] prev_q, count_q, count_d;
  logic [7:0] ctrl_q, ctrl_d, cmd_q, cmd_d;
  logic [7:0] len_hi_q, len_hi_d, len_lo_q, len_lo_d;
  logic [7:0] data_q, data_d;
  logic [7:0] len;
  logic       tail, fall, move;

  assign len  = count_q + 8'd1;
  assign tail = (prev_q == EndA) && (byte_i == EndB);
  assign fall = (len >= ReportLen) && (ctrl_d == FallCtrl) && (cmd_d == FallCmd)
                && (data_d == FallData);
  assign move = (len == ReportLen) && (ctrl_d == MoveCtrl) && (cmd_d == MoveCmd)
                && (len_hi_d == MoveLenHi) && (len_lo_d == MoveLenLo);

  // Hunt for the header, capture frame bytes, close on tail or length limit
  always_comb begin
    in_frame_d = in_frame_q;
    count_d    = count_q;
    ctrl_d     = ctrl_q;
    cmd_d      = cmd_q;
    len_hi_d   = len_hi_q;
    len_lo_d   = len_lo_q;
    data_d     = data_q;
    emit_o     = 1'b0;
    result_o   = '0;
    if (!in_frame_q) begin
      if ((prev_q == SyncA) && (byte_i == SyncB)) begin
        in_frame_d = 1'b1;
        count_d    = HeaderLen;
        ctrl_d     = '0;
        cmd_d      = '0;
        len_hi_d   = '0;
        len_lo_d   = '0;
        data_d     = '0;
      end
    end else begin
      unique case (count_q)
        PosCtrl:  ctrl_d   = byte_i;
        PosCmd:   cmd_d    = byte_i;
        PosLenHi: len_hi_d = byte_i;
        PosLenLo: len_lo_d = byte_i;
        PosData:  data_d   = byte_i;
        default:  ;
      endcase
      count_d = len;
      result_o.frame_length = len;
      if (tail) begin
        emit_o                   = 1'b1;
        result_o.fall_event      = fall;
        result_o.movement_report = move;
        result_o.movement_value  = move ? data_d : 8'd0;
        in_frame_d               = 1'b0;
        count_d                  = '0;
      end else if (len >= MaxLen) begin
        emit_o            = 1'b1;
        result_o.overflow = 1'b1;
        in_frame_d        = 1'b0;
        count_d           = '0;
      end
    end
  end

  // Advance parser state on each processed beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      prev_q     <= '0;
      count_q    <= '0;
      ctrl_q     <= '0;
      cmd_q      <= '0;
      len_hi_q   <= '0;
      len_lo_q   <= '0;
      data_q     <= '0;
    end else if (step_i) begin
      in_frame_q <= in_frame_d;
      prev_q     <= byte_i;
      count_q    <= count_d;
      ctrl_q     <= ctrl_d;
      cmd_q      <= cmd_d;
      len_hi_q   <= len_hi_d;
      len_lo_q   <= len_lo_d;
      data_q     <= data_d;
    end
  end

endmodule

[src/rfdc_out_stage.sv]
module rfdc_out_stage
  import rfdc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 emit_i,
  input  rfdc_result_t         result_i,
  output logic                 free_o,
  rfdc_result_if.source        result_o
);

  logic         valid_q, valid_d;
  rfdc_result_t data_q;

  // Register is free when empty or being drained this cycle
  assign free_o  = !valid_q || result_o.ready;
  assign valid_d = free_o ? (step_i && emit_i) : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload only when a new result enters
  always_ff @(posedge clk_i) begin
    if (free_o && step_i && emit_i) begin
      data_q <= result_i;
    end
  end

  assign result_o.valid           = valid_q;
  assign result_o.fall_event      = data_q.fall_event;
  assign result_o.movement_report = data_q.movement_report;
  assign result_o.movement_value  = data_q.movement_value;
  assign result_o.frame_length    = data_q.frame_length;
  assign result_o.overflow        = data_q.overflow;

endmodule

[src/radar_frame_deframer_classifier.sv]
// Channel   | Dir | Payload                                            | Beat
// byte_i    | in  | rx_byte[7:0]                                       | one serial byte
// result_o  | out | fall_event, movement_report, movement_value[7:0],  | one closed or
//           |     | frame_length[7:0], overflow                        | dropped frame
//
// One byte per cycle unless stalled: input register, one parser step, result register.
// Result valid rises at the edge that steps the closing byte into the result register.
// Reset (async, active low) returns the parser to hunting with all state cleared.
// A stalled result holds the parser only when the input register also holds a byte;
// bytes that neither close nor drop a frame keep flowing while a result waits.
module radar_frame_deframer_classifier
  import rfdc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_LEN = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rfdc_byte_if.sink     byte_i,
  rfdc_result_if.source result_o
);

  logic         in_valid_q, in_valid_d;
  logic [7:0]   in_byte_q;
  logic         step, emit, free;
  rfdc_result_t result;

  // Parser steps when a byte is held and it emits nothing or the result register is free
  assign step         = in_valid_q && (free || !emit);
  assign byte_i.ready = !in_valid_q || step;
  assign in_valid_d   = byte_i.valid ? 1'b1 : (in_valid_q && !step);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.rx_byte;
    end
  end

  rfdc_parser #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (in_byte_q),
    .emit_o  (emit),
    .result_o(result)
  );

  rfdc_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .emit_i  (emit),
    .result_i(result),
    .free_o  (free),
    .result_o(result_o)
  );

  // Dropped frames always report the limit and no classification
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.overflow |->
      result_o.frame_length == 8'(MAX_FRAME_LEN) && !result_o.fall_event &&
      !result_o.movement_report)
    else $error("overflow result with bad fields");

  // Movement reports come only from ten-byte frames
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.movement_report |-> result_o.frame_length == ReportLen)
    else $error("movement report with wrong length");

  // Movement value is zero unless a movement report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.movement_report |-> result_o.movement_value == 8'd0)
    else $error("stray movement value");

  // A held byte that would emit into a blocked result register stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && emit && result_o.valid && !result_o.ready |-> !byte_i.ready)
    else $error("input taken while parser blocked");

endmodule

[verif/tb_radar_frame_deframer_classifier.sv]
module tb_radar_frame_deframer_classifier;
  import rfdc_pkg::*;

  localparam int unsigned FrameLimit = 128;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseBytes = 500;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 8;

  typedef struct {
    logic [7:0]   rx;
    bit           typed;
    rfdc_result_t want;
  } dir_step_t;

  logic clk_i;
  logic rst_ni;

  rfdc_byte_if   byte_ch ();
  rfdc_result_if report_ch ();

  radar_frame_deframer_classifier #(
    .MAX_FRAME_LEN(FrameLimit)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_ch),
    .result_o(report_ch)
  );

  // Parser shadow state
  bit         parsing;
  logic [7:0] last_byte;
  logic [7:0] frame_pos;
  logic [7:0] hdr_ctrl;
  logic [7:0] hdr_cmd;
  logic [7:0] hdr_len_hi;
  logic [7:0] hdr_len_lo;
  logic [7:0] data0;

  rfdc_result_t pending_reports[$];

  int          errors;
  int unsigned sent_bytes;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_left;

  // Short frame, movement report with extreme value, fall report
  dir_step_t dir_steps[24] = '{
    '{8'h53, 1'b0, '0},
    '{8'h59, 1'b0, '0},
    '{8'h54, 1'b0, '0},
    '{8'h43, 1'b1, '{1'b0, 1'b0, 8'h00, 8'd4, 1'b0}},
    '{8'h53, 1'b0, '0},
    '{8'h59, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h03, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h54, 1'b0, '0},
    '{8'h43, 1'b1, '{1'b0, 1'b1, 8'hFF, 8'd10, 1'b0}},
    '{8'h53, 1'b0, '0},
    '{8'h59, 1'b0, '0},
    '{8'h83, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h54, 1'b0, '0},
    '{8'h43, 1'b1, '{1'b1, 1'b0, 8'h00, 8'd10, 1'b0}}
  };

  // Clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Advance the shadow parser by one byte; return 1 when a frame closes or drops
  function automatic bit deframe_byte(input logic [7:0] b, output rfdc_result_t r);
    logic [7:0] len;
    bit         has;
    has = 1'b0;
    r   = '0;
    if (!parsing) begin
      if (last_byte == SyncA && b == SyncB) begin
        parsing    = 1'b1;
        frame_pos  = HeaderLen;
        hdr_ctrl   = '0;
        hdr_cmd    = '0;
        hdr_len_hi = '0;
        hdr_len_lo = '0;
        data0      = '0;
      end
    end else begin
      len = frame_pos + 8'd1;
      case (frame_pos)
        PosCtrl:  hdr_ctrl   = b;
        PosCmd:   hdr_cmd    = b;
        PosLenHi: hdr_len_hi = b;
        PosLenLo: hdr_len_lo = b;
        PosData:  data0      = b;
        default: ;
      endcase
      frame_pos = len;
      if (last_byte == EndA && b == EndB) begin
        r.fall_event      = (len >= ReportLen) && hdr_ctrl == FallCtrl &&
                            hdr_cmd == FallCmd && data0 == FallData;
        r.movement_report = (len == ReportLen) && hdr_ctrl == MoveCtrl &&
                            hdr_cmd == MoveCmd && hdr_len_hi == MoveLenHi &&
                            hdr_len_lo == MoveLenLo;
        r.movement_value  = r.movement_report ? data0 : 8'h00;
        r.frame_length    = len;
        has       = 1'b1;
        parsing   = 1'b0;
        frame_pos = '0;
      end else if (int'(len) >= FrameLimit) begin
        r.frame_length = len;
        r.overflow     = 1'b1;
        has       = 1'b1;
        parsing   = 1'b0;
        frame_pos = '0;
      end
    end
    last_byte = b;
    return has;
  endfunction

  // Offer one beat, wait for it to be taken, then log what it should produce
  task automatic put_byte(input logic [7:0] b, input bit typed, input rfdc_result_t want);
    rfdc_result_t r;
    bit           has;
    if ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid = 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    end
    byte_ch.valid   = 1'b1;
    byte_ch.rx_byte = b;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    has = deframe_byte(b, r);
    if (typed) pending_reports.push_back(want);
    else if (has) pending_reports.push_back(r);
    sent_bytes++;
    @(negedge clk_i);
  endtask

  // Random byte, leaning toward delimiters and header codes
  function automatic logic [7:0] pick_byte();
    logic [7:0] codes[9] = '{SyncA, SyncB, EndA, EndB, FallCtrl, MoveCtrl,
                             8'h01, 8'h03, 8'h00};
    if ($urandom_range(3) == 0) return codes[$urandom_range(8)];
    return 8'($urandom_range(255));
  endfunction

  // Random frame, mostly ten bytes long, half with a movement or fall header
  task automatic send_report_frame();
    int unsigned len;
    int unsigned kind;
    logic [7:0]  b;
    kind = $urandom_range(3);
    len  = ($urandom_range(9) < 7) ? 10 : $urandom_range(4, 20);
    put_byte(SyncA, 1'b0, '0);
    put_byte(SyncB, 1'b0, '0);
    for (int unsigned pos = 2; pos < len - 2; pos++) begin
      b = pick_byte();
      if (kind == 0) begin
        case (pos)
          2: b = MoveCtrl;
          3: b = MoveCmd;
          4: b = MoveLenHi;
          5: b = MoveLenLo;
          default: ;
        endcase
      end else if (kind == 1) begin
        case (pos)
          2: b = FallCtrl;
          3: b = FallCmd;
          6: if ($urandom_range(3) != 0) b = FallData;
          default: ;
        endcase
      end
      put_byte(b, 1'b0, '0);
    end
    put_byte(EndA, 1'b0, '0);
    put_byte(EndB, 1'b0, '0);
  endtask

  // Frame that runs to the length limit: dropped, or closed on its last two bytes
  task automatic send_long_frame(input bit closed);
    int unsigned body;
    logic [7:0]  b;
    body = closed ? FrameLimit - 4 : FrameLimit - 2 + $urandom_range(3);
    put_byte(SyncA, 1'b0, '0);
    put_byte(SyncB, 1'b0, '0);
    repeat (body) begin
      b = pick_byte();
      if (b == EndA) b = ~b;
      put_byte(b, 1'b0, '0);
    end
    if (closed) begin
      put_byte(EndA, 1'b0, '0);
      put_byte(EndB, 1'b0, '0);
    end
  endtask

  // Receiver: long hold-off when requested, otherwise random stalls
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      report_ch.ready = 1'b0;
      hold_left--;
    end else begin
      report_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk_i) begin
    rfdc_result_t exp_r;
    if (rst_ni && report_ch.valid && report_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result: frame_length %0d overflow %0b",
               report_ch.frame_length, report_ch.overflow);
        errors++;
      end else begin
        exp_r = pending_reports.pop_front();
        if (report_ch.fall_event !== exp_r.fall_event) begin
          $error("fall_event: expected %0b, got %0b", exp_r.fall_event, report_ch.fall_event);
          errors++;
        end
        if (report_ch.movement_report !== exp_r.movement_report) begin
          $error("movement_report: expected %0b, got %0b",
                 exp_r.movement_report, report_ch.movement_report);
          errors++;
        end
        if (report_ch.movement_value !== exp_r.movement_value) begin
          $error("movement_value: expected %0h, got %0h",
                 exp_r.movement_value, report_ch.movement_value);
          errors++;
        end
        if (report_ch.frame_length !== exp_r.frame_length) begin
          $error("frame_length: expected %0d, got %0d",
                 exp_r.frame_length, report_ch.frame_length);
          errors++;
        end
        if (report_ch.overflow !== exp_r.overflow) begin
          $error("overflow: expected %0b, got %0b", exp_r.overflow, report_ch.overflow);
          errors++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus
  initial begin
    errors            = 0;
    sent_bytes        = 0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    hold_left         = 0;
    parsing           = 1'b0;
    last_byte         = '0;
    frame_pos         = '0;
    hdr_ctrl          = '0;
    hdr_cmd           = '0;
    hdr_len_hi        = '0;
    hdr_len_lo        = '0;
    data0             = '0;
    byte_ch.valid     = 1'b0;
    byte_ch.rx_byte   = '0;
    report_ch.ready   = 1'b0;
    rst_ni            = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed rows
    foreach (dir_steps[i]) put_byte(dir_steps[i].rx, dir_steps[i].typed, dir_steps[i].want);

    // Hold the result side off while frames keep coming, so the input backs up
    byte_ch.valid = 1'b0;
    @(posedge clk_i);
    hold_left = HoldCycles;
    @(negedge clk_i);
    send_long_frame(1'b0);
    send_long_frame(1'b1);

    // Random frames and noise across idling phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      sent_bytes = 0;
      while (sent_bytes < PhaseBytes) begin
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
          repeat ($urandom_range(1, 6)) put_byte(pick_byte(), 1'b0, '0);
        end else if (pick < 12) begin
          send_long_frame(1'b0);
        end else if (pick < 13) begin
          send_long_frame(1'b1);
        end else begin
          send_report_frame();
        end
      end
    end

    // Drain
    byte_ch.valid = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
